FILE: rtl/msbs_pkg.sv
// Constants, signature table and shared types of the multi-signature byte scanner.
package msbs_pkg;

    localparam int MaxBufferBytes = 4194304;
    localparam int WindowBytes    = 40;
    localparam int SigCount       = 11;
    localparam int HistDepth      = WindowBytes - 1;
    localparam int PosW           = $clog2(MaxBufferBytes);
    localparam int IdxW           = 4;
    localparam int CntW           = 4;
    localparam int LenW           = 7;
    localparam int SigBits        = WindowBytes * 8;

    localparam logic [PosW-1:0] PosCeil = PosW'(MaxBufferBytes - 1);

    // last byte of each signature sits in the low byte
    localparam logic [SigBits-1:0] SigText [SigCount] = '{
        SigBits'("AAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAA"),
        SigBits'("<script>console.error"),
        SigBits'("' OR ''='"),
        SigBits'("%d %s %d %s"),
        SigBits'("XNU Image Fuzzer"),
        SigBits'("DROP TABLE"),
        SigBits'("!@#$%^&*()_+="),
        SigBits'("..//..//..//"),
        SigBits'("<!DOCTYPE"),
        SigBits'(32'hFFFF_FFFF),
        SigBits'(16'h002B)
    };

    localparam logic [LenW-1:0] SigLen [SigCount] = '{
        LenW'(40), LenW'(21), LenW'(9), LenW'(11), LenW'(16), LenW'(10),
        LenW'(13), LenW'(12), LenW'(9), LenW'(4), LenW'(2)
    };

    typedef struct packed {
        logic [SigCount-1:0] mask;
        logic [PosW-1:0]     pos;
        logic                sat;
        logic                summary;
        logic [CntW-1:0]     count;
    } t_event;

endpackage

FILE: rtl/msbs_match.sv
// Byte history, buffer position and parallel signature compare.
module msbs_match (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_end_of_buffer,
    output msbs_pkg::t_event      o_event,
    output logic                  o_has_result
);

    logic [7:0]                     r_hist [msbs_pkg::HistDepth];
    logic [msbs_pkg::PosW-1:0]      r_pos;
    logic [msbs_pkg::SigCount-1:0]  r_found;
    logic [msbs_pkg::CntW-1:0]      r_total;

    logic [7:0]                     w_win [msbs_pkg::WindowBytes];
    logic [msbs_pkg::SigCount-1:0]  w_hits;
    logic [msbs_pkg::CntW-1:0]      w_new_cnt;
    logic [msbs_pkg::CntW-1:0]      n_total;

    always_comb begin
        w_win[0] = i_data_byte;
        for (int k = 1; k < msbs_pkg::WindowBytes; k++) begin
            w_win[k] = r_hist[k-1];
        end
    end

    always_comb begin
        logic ok;
        for (int s = 0; s < msbs_pkg::SigCount; s++) begin
            ok = !r_found[s]
                && (int'(msbs_pkg::SigLen[s]) <= msbs_pkg::WindowBytes)
                && (r_pos >= msbs_pkg::PosW'(msbs_pkg::SigLen[s] - 1'b1));
            for (int k = 0; k < msbs_pkg::WindowBytes; k++) begin
                if (k < int'(msbs_pkg::SigLen[s])
                        && w_win[k] != msbs_pkg::SigText[s][k*8 +: 8]) begin
                    ok = 1'b0;
                end
            end
            w_hits[s] = ok;
        end
    end

    always_comb begin
        w_new_cnt = '0;
        for (int s = 0; s < msbs_pkg::SigCount; s++) begin
            w_new_cnt = w_new_cnt + msbs_pkg::CntW'(w_hits[s]);
        end
        n_total = r_total + w_new_cnt;
    end

    always_comb begin
        o_event.mask    = w_hits;
        o_event.pos     = r_pos;
        o_event.sat     = (r_pos >= msbs_pkg::PosCeil);
        o_event.summary = i_end_of_buffer;
        o_event.count   = n_total;
        o_has_result    = (|w_hits) || i_end_of_buffer;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_found <= '0;
            r_total <= '0;
        end else if (i_accept) begin
            if (i_end_of_buffer) begin
                r_pos   <= '0;
                r_found <= '0;
                r_total <= '0;
            end else begin
                if (r_pos < msbs_pkg::PosCeil) begin
                    r_pos <= r_pos + 1'b1;
                end
                r_found <= r_found | w_hits;
                r_total <= n_total;
            end
        end
    end

    // history content before the buffer start is masked by the position check
    always_ff @(posedge i_clk) begin
        if (i_accept && !i_end_of_buffer) begin
            r_hist[0] <= i_data_byte;
            for (int k = 1; k < msbs_pkg::HistDepth; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

endmodule

FILE: rtl/msbs_emit.sv
// Event holding register and result output register, one result word per cycle while not stalled.
module msbs_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  msbs_pkg::t_event           i_event,
    output logic                       o_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_is_summary,
    output logic [msbs_pkg::IdxW-1:0]  o_signature_index,
    output logic [msbs_pkg::PosW-1:0]  o_match_offset,
    output logic [msbs_pkg::CntW-1:0]  o_distinct_found,
    output logic                       o_last_result
);

    logic                           r_ev_valid;
    msbs_pkg::t_event               r_ev;
    logic                           r_out_valid;
    logic                           r_is_summary;
    logic [msbs_pkg::IdxW-1:0]      r_index;
    logic [msbs_pkg::PosW-1:0]      r_offset;
    logic [msbs_pkg::CntW-1:0]      r_count;
    logic                           r_last;

    logic                           w_out_load;
    logic                           w_emit;
    logic                           w_any;
    logic [msbs_pkg::IdxW-1:0]      w_sel;
    logic [msbs_pkg::SigCount-1:0]  n_mask;
    logic                           w_last;
    logic                           w_done;
    logic [msbs_pkg::PosW-1:0]      w_offset;

    always_comb begin
        w_out_load = !r_out_valid || !i_out_stall;
        w_emit     = r_ev_valid && w_out_load;
        w_any      = |r_ev.mask;
        w_sel      = '0;
        for (int s = msbs_pkg::SigCount - 1; s >= 0; s--) begin
            if (r_ev.mask[s]) begin
                w_sel = msbs_pkg::IdxW'(s);
            end
        end
        for (int s = 0; s < msbs_pkg::SigCount; s++) begin
            n_mask[s] = r_ev.mask[s] && (msbs_pkg::IdxW'(s) != w_sel);
        end
        w_last   = w_any ? (n_mask == '0) && !r_ev.summary : 1'b1;
        w_done   = w_emit && w_last;
        o_ready  = !r_ev_valid || w_done;
        w_offset = r_ev.sat ? msbs_pkg::PosCeil
                 : r_ev.pos - msbs_pkg::PosW'(msbs_pkg::SigLen[w_sel] - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
        end else if (i_push) begin
            r_ev_valid <= 1'b1;
        end else if (w_done) begin
            r_ev_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ev <= i_event;
        end else if (w_emit && w_any) begin
            r_ev.mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_ev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_is_summary <= !w_any;
            r_index      <= w_any ? w_sel : '0;
            r_offset     <= w_any ? w_offset : '0;
            r_count      <= w_any ? '0 : r_ev.count;
            r_last       <= w_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_is_summary      = r_is_summary;
    assign o_signature_index = r_index;
    assign o_match_offset    = r_offset;
    assign o_distinct_found  = r_count;
    assign o_last_result     = r_last;

endmodule

FILE: rtl/multi_signature_byte_scanner.sv
// Top level of the multi-signature byte scanner.
//
//   channel | direction | handshake                 | word
//   input   | in        | i_in_valid / o_in_stall   | data_byte, end_of_buffer
//   result  | out       | o_out_valid / i_out_stall | is_summary .. last_result
//
// A byte is compared against all eleven signatures in the cycle it is taken.
// One result word leaves per cycle from the output register unless stalled;
// a byte causing n results holds the input until its last result is emitted,
// so, unstalled, one byte per cycle with at most one result each. Reset is
// synchronous, active low, and clears position, found mask and handshake
// state. Output stall backs up through the event register into o_in_stall.
module multi_signature_byte_scanner (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_end_of_buffer,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_is_summary,
    output logic [msbs_pkg::IdxW-1:0]  o_signature_index,
    output logic [msbs_pkg::PosW-1:0]  o_match_offset,
    output logic [msbs_pkg::CntW-1:0]  o_distinct_found,
    output logic                       o_last_result
);

    logic             w_ready;
    logic             w_accept;
    logic             w_has_result;
    msbs_pkg::t_event w_event;

    assign o_in_stall = !w_ready;
    assign w_accept   = i_in_valid && w_ready;

    msbs_match u_match (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_event         (w_event),
        .o_has_result    (w_has_result)
    );

    msbs_emit u_emit (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (w_accept && w_has_result),
        .i_event           (w_event),
        .o_ready           (w_ready),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_is_summary      (o_is_summary),
        .o_signature_index (o_signature_index),
        .o_match_offset    (o_match_offset),
        .o_distinct_found  (o_distinct_found),
        .o_last_result     (o_last_result)
    );

endmodule
